### hw/rtl/mlfq_pkg.sv
package mlfq_pkg;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_PARTIAL  = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [1:0] LVL_NONE  = 2'd0;
    localparam logic [1:0] LVL_ONE   = 2'd1;
    localparam logic [1:0] LVL_TWO   = 2'd2;
    localparam logic [1:0] LVL_THREE = 2'd3;

    localparam logic [0:0] CFG_L1_QUANTUM = 1'd0;
    localparam logic [0:0] CFG_L2_QUANTUM = 1'd1;

    localparam logic [23:0] L1_QUANTUM_RESET = 24'd8192;
    localparam logic [23:0] L2_QUANTUM_RESET = 24'd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_APPLY,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_ENQ,
        CMD_SERVE
    } t_cmd_kind;

    typedef struct packed {
        logic        go;
        logic        free_hit;
        logic        head_hit;
        logic [15:0] head_tag;
        logic [31:0] head_rem;
    } t_scan;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [1:0]  lvl;
        logic [1:0]  next_lvl;
        logic        finished;
        logic [15:0] tag;
        logic [31:0] rem;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  slot;
        logic [15:0] served_tag;
        logic [31:0] bytes_sent;
        logic [1:0]  served_level;
    } t_result;

endpackage

### hw/rtl/mlfq_req_if.sv
interface mlfq_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] client_tag;
    logic [31:0] request_length;

    modport source (output valid, output op, output client_tag, output request_length,
                    input ready);
    modport sink (input valid, input op, input client_tag, input request_length,
                  output ready);
endinterface

### hw/rtl/mlfq_res_if.sv
interface mlfq_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  slot;
    logic [15:0] served_tag;
    logic [31:0] bytes_sent;
    logic [1:0]  served_level;

    modport source (output valid, output status, output slot, output served_tag,
                    output bytes_sent, output served_level, input ready);
    modport sink (input valid, input status, input slot, input served_tag,
                  input bytes_sent, input served_level, output ready);
endinterface

### hw/rtl/mlfq_request_scheduler.sv
// Three-level feedback scheduler over a table of TABLE_DEPTH transfer requests.
// An enqueue request (op 0) stores the tag and length in the lowest free slot at
// the tail of level 1, or reports table full. A serve request (op 1) grants the
// head of the highest non-empty level min(remaining, quantum) bytes (level 3
// takes all that remains), demotes an unfinished entry to the tail of the next
// level and frees a finished one. Quanta for levels 1 and 2 are registers 0 and
// 1 (reset 8192 and 65536); write them only while no request is in flight.
// A request with a table search sends a search wavefront along the row of table
// cells one slot per cycle, then computes the grant and applies the update; a
// serve with nothing waiting skips the search and the grant step. One request is in
// flight at a time, and a new one is taken while the previous result waits.
module mlfq_request_scheduler
    import mlfq_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlfq_req_if.sink    i_req,
    mlfq_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state        r_state, n_state;
    logic          r_op, n_op;
    logic [15:0]   r_tag, n_tag;
    logic [31:0]   r_len, n_len;
    logic [1:0]    r_lvl, n_lvl;
    logic          r_launch, n_launch;
    t_scan         r_pkt, n_pkt;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [IW-1:0] r_head_idx, n_head_idx;
    logic [31:0]   r_grant, n_grant;
    t_result       r_res, n_res;
    t_result       r_out, n_out;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] r_cnt1, n_cnt1;
    logic [CW-1:0] r_cnt2, n_cnt2;
    logic [CW-1:0] r_cnt3, n_cnt3;
    logic [23:0]   r_q1, n_q1;
    logic [23:0]   r_q2, n_q2;

    logic          w_ready;
    logic          w_accept;
    logic [1:0]    w_pick_lvl;
    t_cmd          w_cmd;
    logic [IW-1:0] w_cmd_idx;
    logic [IW-1:0] w_cmd_order;
    logic [31:0]   w_quantum;
    logic [31:0]   w_rem_left;
    logic          w_finished;
    logic [1:0]    w_next_lvl;

    t_scan         w_scan     [0:TABLE_DEPTH];
    logic [IW-1:0] w_free_idx [0:TABLE_DEPTH];
    logic [IW-1:0] w_head_idx [0:TABLE_DEPTH];

    assign w_accept = i_req.valid && w_ready;

    always_comb begin
        if (r_cnt1 != '0) begin
            w_pick_lvl = LVL_ONE;
        end else if (r_cnt2 != '0) begin
            w_pick_lvl = LVL_TWO;
        end else if (r_cnt3 != '0) begin
            w_pick_lvl = LVL_THREE;
        end else begin
            w_pick_lvl = LVL_NONE;
        end
    end

    assign w_quantum  = (r_lvl == LVL_ONE) ? {8'd0, r_q1} : {8'd0, r_q2};
    assign w_rem_left = r_pkt.head_rem - r_grant;
    assign w_finished = (w_rem_left == '0);
    assign w_next_lvl = (r_lvl == LVL_THREE) ? LVL_THREE : r_lvl + 2'd1;

    assign w_scan[0]     = '{go: r_launch, free_hit: 1'b0, head_hit: 1'b0,
                             head_tag: 16'd0, head_rem: 32'd0};
    assign w_free_idx[0] = '0;
    assign w_head_idx[0] = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        mlfq_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_scan          (w_scan[g]),
            .i_scan_free_idx (w_free_idx[g]),
            .i_scan_head_idx (w_head_idx[g]),
            .o_scan          (w_scan[g+1]),
            .o_scan_free_idx (w_free_idx[g+1]),
            .o_scan_head_idx (w_head_idx[g+1]),
            .i_cmd           (w_cmd),
            .i_cmd_idx       (w_cmd_idx),
            .i_cmd_order     (w_cmd_order)
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.op == OP_SERVE && w_pick_lvl == LVL_NONE) begin
                        n_state = S_APPLY;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan[TABLE_DEPTH].go) begin
                    n_state = S_CALC;
                end
            end
            S_CALC:  n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ready     = 1'b0;
        w_cmd       = '{kind: CMD_NONE, lvl: r_lvl, next_lvl: w_next_lvl,
                        finished: w_finished, tag: r_tag, rem: r_len};
        w_cmd_idx   = r_free_idx;
        w_cmd_order = IW'(r_cnt1);
        case (r_state)
            S_IDLE: w_ready = 1'b1;
            S_APPLY: begin
                if (r_op == OP_ENQUEUE) begin
                    if (r_pkt.free_hit) begin
                        w_cmd.kind = CMD_ENQ;
                    end
                end else if (r_lvl != LVL_NONE) begin
                    w_cmd.kind = CMD_SERVE;
                    w_cmd.rem  = w_rem_left;
                    w_cmd_idx  = r_head_idx;
                    if (r_lvl == LVL_THREE) begin
                        w_cmd_order = IW'(r_cnt3 - 1'b1);
                    end else if (r_lvl == LVL_TWO) begin
                        w_cmd_order = IW'(r_cnt3);
                    end else begin
                        w_cmd_order = IW'(r_cnt2);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_op        = r_op;
        n_tag       = r_tag;
        n_len       = r_len;
        n_lvl       = r_lvl;
        n_launch    = 1'b0;
        n_pkt       = r_pkt;
        n_free_idx  = r_free_idx;
        n_head_idx  = r_head_idx;
        n_grant     = r_grant;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_cnt1      = r_cnt1;
        n_cnt2      = r_cnt2;
        n_cnt3      = r_cnt3;
        n_q1        = r_q1;
        n_q2        = r_q2;

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_L1_QUANTUM: n_q1 = i_cfg_data;
                CFG_L2_QUANTUM: n_q2 = i_cfg_data;
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = i_req.op;
                    n_tag = i_req.client_tag;
                    n_len = i_req.request_length;
                    n_lvl = (i_req.op == OP_SERVE) ? w_pick_lvl : LVL_NONE;
                    n_launch = !(i_req.op == OP_SERVE && w_pick_lvl == LVL_NONE);
                end
            end
            S_SCAN: begin
                if (w_scan[TABLE_DEPTH].go) begin
                    n_pkt      = w_scan[TABLE_DEPTH];
                    n_free_idx = w_free_idx[TABLE_DEPTH];
                    n_head_idx = w_head_idx[TABLE_DEPTH];
                end
            end
            S_CALC: begin
                if (r_lvl == LVL_THREE || r_pkt.head_rem < w_quantum) begin
                    n_grant = r_pkt.head_rem;
                end else begin
                    n_grant = w_quantum;
                end
            end
            S_APPLY: begin
                n_res = '0;
                if (r_op == OP_ENQUEUE) begin
                    if (r_pkt.free_hit) begin
                        n_res.status = ST_ACCEPTED;
                        n_res.slot   = 7'(r_free_idx);
                        n_cnt1       = r_cnt1 + 1'b1;
                    end else begin
                        n_res.status = ST_FULL;
                    end
                end else if (r_lvl == LVL_NONE) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.status       = w_finished ? ST_FINISHED : ST_PARTIAL;
                    n_res.slot         = 7'(r_head_idx);
                    n_res.served_tag   = r_pkt.head_tag;
                    n_res.bytes_sent   = r_grant;
                    n_res.served_level = r_lvl;
                    case (r_lvl)
                        LVL_ONE: begin
                            n_cnt1 = r_cnt1 - 1'b1;
                            if (!w_finished) begin
                                n_cnt2 = r_cnt2 + 1'b1;
                            end
                        end
                        LVL_TWO: begin
                            n_cnt2 = r_cnt2 - 1'b1;
                            if (!w_finished) begin
                                n_cnt3 = r_cnt3 + 1'b1;
                            end
                        end
                        default: begin
                            if (w_finished) begin
                                n_cnt3 = r_cnt3 - 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_cnt3      <= '0;
            r_q1        <= L1_QUANTUM_RESET;
            r_q2        <= L2_QUANTUM_RESET;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
            r_cnt1      <= n_cnt1;
            r_cnt2      <= n_cnt2;
            r_cnt3      <= n_cnt3;
            r_q1        <= n_q1;
            r_q2        <= n_q2;
        end
        r_op       <= n_op;
        r_tag      <= n_tag;
        r_len      <= n_len;
        r_lvl      <= n_lvl;
        r_pkt      <= n_pkt;
        r_free_idx <= n_free_idx;
        r_head_idx <= n_head_idx;
        r_grant    <= n_grant;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign i_req.ready        = w_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.slot         = r_out.slot;
    assign o_res.served_tag   = r_out.served_tag;
    assign o_res.bytes_sent   = r_out.bytes_sent;
    assign o_res.served_level = r_out.served_level;

    a_scan_end_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan[TABLE_DEPTH].go |-> r_state == S_SCAN)
        else $error("search wavefront left the row outside a scan");

    a_head_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC && r_op == OP_SERVE) |-> r_pkt.head_hit)
        else $error("non-empty level has no head entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_cnt1) + 32'(r_cnt2) + 32'(r_cnt3)) <= 32'(TABLE_DEPTH))
        else $error("level populations exceed table depth");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_op == OP_ENQUEUE && r_pkt.free_hit)
            |=> r_cnt1 == $past(r_cnt1) + 1'b1)
        else $error("level one population not advanced on enqueue");

endmodule

### hw/rtl/mlfq_cell.sv
module mlfq_cell
    import mlfq_pkg::*;
#(
    parameter int IW  = 7,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_scan         i_scan,
    input  logic [IW-1:0] i_scan_free_idx,
    input  logic [IW-1:0] i_scan_head_idx,
    output t_scan         o_scan,
    output logic [IW-1:0] o_scan_free_idx,
    output logic [IW-1:0] o_scan_head_idx,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_cmd_idx,
    input  logic [IW-1:0] i_cmd_order
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic          r_valid, n_valid;
    logic [15:0]   r_tag, n_tag;
    logic [31:0]   r_rem, n_rem;
    logic [1:0]    r_level, n_level;
    logic [IW-1:0] r_order, n_order;

    t_scan         r_scan, n_scan;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic [IW-1:0] r_head_idx, n_head_idx;

    // scan: claim the first free slot, report the head of the searched level
    always_comb begin
        n_scan     = i_scan;
        n_free_idx = i_scan_free_idx;
        n_head_idx = i_scan_head_idx;
        if (!r_valid && !i_scan.free_hit) begin
            n_scan.free_hit = 1'b1;
            n_free_idx      = MY_IDX;
        end
        if (r_valid && r_level == i_cmd.lvl && r_order == '0) begin
            n_scan.head_hit = 1'b1;
            n_scan.head_tag = r_tag;
            n_scan.head_rem = r_rem;
            n_head_idx      = MY_IDX;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_tag   = r_tag;
        n_rem   = r_rem;
        n_level = r_level;
        n_order = r_order;
        case (i_cmd.kind)
            CMD_ENQ: begin
                if (i_cmd_idx == MY_IDX) begin
                    n_valid = 1'b1;
                    n_tag   = i_cmd.tag;
                    n_rem   = i_cmd.rem;
                    n_level = LVL_ONE;
                    n_order = i_cmd_order;
                end
            end
            CMD_SERVE: begin
                if (i_cmd_idx == MY_IDX) begin
                    if (i_cmd.finished) begin
                        n_valid = 1'b0;
                    end else begin
                        n_level = i_cmd.next_lvl;
                        n_order = i_cmd_order;
                        n_rem   = i_cmd.rem;
                    end
                end else if (r_valid && r_level == i_cmd.lvl && r_order != '0) begin
                    n_order = r_order - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_scan.go <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_scan  <= n_scan;
        end
        r_tag      <= n_tag;
        r_rem      <= n_rem;
        r_level    <= n_level;
        r_order    <= n_order;
        r_free_idx <= n_free_idx;
        r_head_idx <= n_head_idx;
    end

    assign o_scan          = r_scan;
    assign o_scan_free_idx = r_free_idx;
    assign o_scan_head_idx = r_head_idx;

endmodule

### sim/mlfq_request_scheduler_tb.sv
`timescale 1ns / 1ps

module mlfq_request_scheduler_tb;
    import mlfq_pkg::*;

    localparam int TABLE_DEPTH = 128;

    typedef struct packed {
        logic        op;
        logic [15:0] tag;
        logic [31:0] length;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    mlfq_req_if req_if ();
    mlfq_res_if res_if ();

    mlfq_request_scheduler #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_res     (res_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    t_request    pending_requests[$];
    t_result     expected_results[$];

    bit          slot_busy[TABLE_DEPTH];
    logic [15:0] slot_tag[TABLE_DEPTH];
    logic [31:0] slot_left[TABLE_DEPTH];
    logic [1:0]  slot_level[TABLE_DEPTH];
    int unsigned slot_rank[TABLE_DEPTH];
    logic [23:0] quantum_l1;
    logic [23:0] quantum_l2;

    bit          req_fired;
    bit          steady;
    bit          stall_done;
    int unsigned stall_left;
    int unsigned results_seen;
    int unsigned requests_sent;
    int unsigned errors;
    int unsigned status_count[5];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_result schedule_request(logic op, logic [15:0] tag, logic [31:0] len);
        t_result     r;
        int          free_idx;
        int          pick;
        int unsigned n;
        int unsigned gone;
        logic [1:0]  lvl;
        logic [1:0]  nxt;
        logic [31:0] left;
        logic [31:0] grant;
        r = '0;
        if (op == OP_ENQUEUE) begin
            free_idx = -1;
            for (int k = 0; k < TABLE_DEPTH; k++)
                if (!slot_busy[k] && free_idx < 0) free_idx = k;
            if (free_idx < 0) begin
                r.status = ST_FULL;
                return r;
            end
            n = 0;
            for (int k = 0; k < TABLE_DEPTH; k++)
                if (slot_busy[k] && slot_level[k] == LVL_ONE) n++;
            slot_rank[free_idx]  = n;
            slot_busy[free_idx]  = 1'b1;
            slot_tag[free_idx]   = tag;
            slot_left[free_idx]  = len;
            slot_level[free_idx] = LVL_ONE;
            r.status = ST_ACCEPTED;
            r.slot   = 7'(free_idx);
            return r;
        end
        pick = -1;
        for (int l = 1; l <= 3 && pick < 0; l++)
            for (int k = 0; k < TABLE_DEPTH; k++)
                if (slot_busy[k] && slot_level[k] == 2'(l) &&
                    (pick < 0 || slot_rank[k] < slot_rank[pick]))
                    pick = k;
        if (pick < 0) begin
            r.status = ST_EMPTY;
            return r;
        end
        lvl  = slot_level[pick];
        left = slot_left[pick];
        case (lvl)
            LVL_ONE: grant = (left < {8'd0, quantum_l1}) ? left : {8'd0, quantum_l1};
            LVL_TWO: grant = (left < {8'd0, quantum_l2}) ? left : {8'd0, quantum_l2};
            default: grant = left;
        endcase
        left = left - grant;
        r.slot         = 7'(pick);
        r.served_tag   = slot_tag[pick];
        r.bytes_sent   = grant;
        r.served_level = lvl;
        gone = slot_rank[pick];
        for (int k = 0; k < TABLE_DEPTH; k++)
            if (slot_busy[k] && slot_level[k] == lvl && k != pick && slot_rank[k] > gone)
                slot_rank[k]--;
        if (left == 0) begin
            slot_busy[pick] = 1'b0;
            slot_left[pick] = '0;
            r.status = ST_FINISHED;
        end else begin
            nxt = (lvl == LVL_THREE) ? LVL_THREE : lvl + 2'd1;
            n = 0;
            for (int k = 0; k < TABLE_DEPTH; k++)
                if (slot_busy[k] && slot_level[k] == nxt && k != pick) n++;
            slot_left[pick]  = left;
            slot_rank[pick]  = n;
            slot_level[pick] = nxt;
            r.status = ST_PARTIAL;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            req_fired = 1'b0;
        end else begin
            req_fired = req_if.valid && req_if.ready;
            if (req_fired) begin
                expected_results.push_back(schedule_request(req_if.op, req_if.client_tag,
                                                            req_if.request_length));
                requests_sent++;
            end
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual status %0h slot %0h",
                             $time, res_if.status, res_if.slot);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status < 5) status_count[want.status]++;
                    check_field("status", 32'(want.status), 32'(res_if.status));
                    check_field("slot", 32'(want.slot), 32'(res_if.slot));
                    check_field("served_tag", 32'(want.served_tag), 32'(res_if.served_tag));
                    check_field("bytes_sent", want.bytes_sent, res_if.bytes_sent);
                    check_field("served_level", 32'(want.served_level),
                                32'(res_if.served_level));
                end
            end
        end
    end

    always @(negedge i_clk) begin : request_driver
        t_request nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fired) begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
                nxt = pending_requests.pop_front();
                req_if.valid          <= 1'b1;
                req_if.op             <= nxt.op;
                req_if.client_tag     <= nxt.tag;
                req_if.request_length <= nxt.length;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (!stall_done && results_seen >= 60) begin
            stall_left   <= 800;
            stall_done   <= 1'b1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= steady || ($urandom_range(0, 99) >= 10);
        end
    end

    function automatic logic [31:0] pick_length(int unsigned scale);
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1, 2:    return $urandom();
            3:       return scale;
            4:       return scale + 1;
            default: return $urandom_range(1, 3 * scale);
        endcase
    endfunction

    task automatic add_enqueue(input logic [15:0] tag, input logic [31:0] len);
        pending_requests.push_back(t_request'{OP_ENQUEUE, tag, len});
    endtask

    task automatic add_serve();
        pending_requests.push_back(t_request'{OP_SERVE, 16'($urandom()), 32'($urandom())});
    endtask

    task automatic add_random_phase(input int count, input int enq_pct,
                                    input int unsigned scale);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < enq_pct) add_enqueue(16'($urandom()), pick_length(scale));
            else add_serve();
        end
    endtask

    task automatic configure(input logic [0:0] idx, input logic [23:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_L1_QUANTUM) quantum_l1 = value;
        else quantum_l2 = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #(20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [23:0] q1;
        logic [23:0] q2;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        quantum_l1            = L1_QUANTUM_RESET;
        quantum_l2            = L2_QUANTUM_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(CFG_L1_QUANTUM, 24'd8192);
        configure(CFG_L2_QUANTUM, 24'd65536);
        add_serve();
        add_enqueue(16'h0000, 32'd0);
        add_enqueue(16'hFFFF, 32'hFFFF_FFFF);
        add_enqueue(16'h1234, 32'd8192);
        add_enqueue(16'h5A5A, 32'd8193);
        add_enqueue(16'h00FF, 32'd1);
        repeat (10) add_serve();
        drain();

        configure(CFG_L1_QUANTUM, 24'd1);
        configure(CFG_L2_QUANTUM, 24'hFF_FFFF);
        for (int i = 0; i < 135; i++) add_enqueue(16'($urandom()), pick_length(64));
        repeat (140) add_serve();
        drain();

        configure(CFG_L1_QUANTUM, 24'd0);
        configure(CFG_L2_QUANTUM, 24'd3);
        add_enqueue(16'hA5A5, 32'd0);
        add_enqueue(16'h5A5A, 32'd7);
        repeat (5) add_serve();
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 3) begin
                q1 = 24'hFF_FFFF;
                q2 = 24'd1;
            end else begin
                q1 = 24'($urandom_range(1, 4096));
                q2 = 24'($urandom_range(1, 65536));
            end
            configure(CFG_L1_QUANTUM, q1);
            configure(CFG_L2_QUANTUM, q2);
            steady = (phase == 1);
            case (phase)
                0:       add_random_phase(290, 70, 32'(q1) + 32'(q2));
                1:       add_random_phase(290, 50, 32'(q1) + 32'(q2));
                2:       add_random_phase(290, 60, 32'(q1) + 32'(q2));
                default: add_random_phase(290, 40, 4096);
            endcase
            drain();
        end
        steady = 1'b0;

        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t ns: %0d results never arrived, expected status %0h",
                     $time, expected_results.size(), expected_results[0].status);
            errors++;
        end
        $display("Covered %0d requests over 7 quantum settings, one long output stall.",
                 requests_sent);
        $display("Results: %0d accepted, %0d full, %0d partial, %0d finished, %0d empty.",
                 status_count[ST_ACCEPTED], status_count[ST_FULL], status_count[ST_PARTIAL],
                 status_count[ST_FINISHED], status_count[ST_EMPTY]);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
